>>> rtl/lbmm_pkg.sv
// ----------------------------------------------------------------------------
// lbmm_pkg
// Shared types and constants of the fixed-latency byte-masked word memory.
// ----------------------------------------------------------------------------
package lbmm_pkg;

    localparam int STORE_WORDS = 4096;
    localparam int STORE_AW    = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int WORD_LANES  = 8;
    localparam int WORD_W      = 8 * WORD_LANES;
    localparam int LANE_SHIFT  = $clog2(WORD_LANES);
    localparam int ADDR_W      = 64;
    localparam int WINDOW_W    = 16;
    localparam int WAIT_W      = 8;
    localparam int CFG_IDX_W   = 2;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_ADDRESS = 2'd0,
        CFG_WINDOW_BYTES = 2'd1,
        CFG_WAIT_CYCLES  = 2'd2
    } cfg_reg_e;

    typedef struct packed {
        logic                  request_valid;
        logic [ADDR_W-1:0]     address;
        logic [WORD_W-1:0]     write_data;
        logic [WORD_LANES-1:0] byte_mask;
        logic                  write_enable;
    } in_item_t;

    typedef struct packed {
        logic              ready_res;
        logic [WORD_W-1:0] read_data;
    } out_item_t;

endpackage

>>> rtl/lbmm_ram.sv
// ----------------------------------------------------------------------------
// lbmm_ram
// Single-port word RAM with byte-lane write enables and a registered read.
// ----------------------------------------------------------------------------
module lbmm_ram #(
    parameter int WORDS = 4096,
    parameter int AW    = (WORDS > 1) ? $clog2(WORDS) : 1,
    parameter int LANES = 8
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic                 rd_en,
    input  logic [AW-1:0]        addr,
    input  logic [LANES-1:0]     lane_en,
    input  logic [8*LANES-1:0]   wdata,
    output logic [8*LANES-1:0]   rdata
);

    logic [8*LANES-1:0] mem [WORDS];
    logic [8*LANES-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int b = 0; b < LANES; b++)
            begin
                if (lane_en[b])
                begin
                    mem[addr][8*b +: 8] <= wdata[8*b +: 8];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/latency_byte_masked_memory.sv
// ----------------------------------------------------------------------------
// latency_byte_masked_memory
// Word memory that serves a request after a programmable wait, inside a
// configurable address window, with byte-masked writes.
// ----------------------------------------------------------------------------
// Each input transaction yields its result transaction in the cycle after it is accepted.
// Throughput: one transaction per cycle while the output is not stalled; the
//   single RAM port takes at most one access (masked write or read) per
//   transaction, and read data comes from the RAM's registered output.
// Reset: clears pending request, wait count, last read data and configuration
//   (window 32768 bytes at base 0, wait 0). RAM contents are not cleared.
module latency_byte_masked_memory (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  lbmm_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output lbmm_pkg::out_item_t                  out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lbmm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [63:0]                          cfg_data
);

    // configuration
    logic [lbmm_pkg::ADDR_W-1:0]   base_reg;
    logic [lbmm_pkg::WINDOW_W-1:0] window_reg;
    logic [lbmm_pkg::WAIT_W-1:0]   wait_reg;

    // pending request
    logic                            pend_reg,  pend_next;
    logic [lbmm_pkg::ADDR_W-1:0]     paddr_reg, paddr_next;
    logic [lbmm_pkg::WORD_W-1:0]     pdata_reg, pdata_next;
    logic [lbmm_pkg::WORD_LANES-1:0] pmask_reg, pmask_next;
    logic                            pwr_reg,   pwr_next;
    logic [lbmm_pkg::WAIT_W-1:0]     count_reg, count_next;

    // result stage
    logic                          out_valid_reg;
    logic                          ready_reg;
    logic                          out_rd_reg;
    logic [lbmm_pkg::WORD_W-1:0]   last_read_reg;

    logic                          in_fire;
    logic                          at_wait;
    logic                          in_window;
    logic                          serve;
    logic [lbmm_pkg::ADDR_W-1:0]   offset;
    logic [lbmm_pkg::ADDR_W-1:0]   word_idx;
    logic [lbmm_pkg::WORD_W-1:0]   ram_rdata;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign in_fire   = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            window_reg <= lbmm_pkg::WINDOW_RESET;
            wait_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lbmm_pkg::CFG_BASE_ADDRESS: base_reg   <= cfg_data;
                lbmm_pkg::CFG_WINDOW_BYTES: window_reg <= cfg_data[lbmm_pkg::WINDOW_W-1:0];
                lbmm_pkg::CFG_WAIT_CYCLES:  wait_reg   <= cfg_data[lbmm_pkg::WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    // A new request replaces the pending one and restarts the count.
    always_comb
    begin
        if (in_data.request_valid)
        begin
            pend_next  = 1'b1;
            paddr_next = in_data.address;
            pdata_next = in_data.write_data;
            pmask_next = in_data.byte_mask;
            pwr_next   = in_data.write_enable;
            count_next = '0;
        end
        else
        begin
            pend_next  = pend_reg;
            paddr_next = paddr_reg;
            pdata_next = pdata_reg;
            pmask_next = pmask_reg;
            pwr_next   = pwr_reg;
            count_next = count_reg;
        end

        offset    = paddr_next - base_reg;
        word_idx  = offset >> lbmm_pkg::LANE_SHIFT;
        at_wait   = (count_next == wait_reg);
        in_window = (paddr_next >= base_reg)
                  && (offset < lbmm_pkg::ADDR_W'(window_reg))
                  && (word_idx < lbmm_pkg::ADDR_W'(lbmm_pkg::STORE_WORDS));
        serve     = pend_next & at_wait & in_window;

        if (serve)
        begin
            pend_next  = 1'b0;
            count_next = '0;
        end
        else if (pend_next && !at_wait)
        begin
            count_next = count_next + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            paddr_reg <= '0;
            pdata_reg <= '0;
            pmask_reg <= '0;
            pwr_reg   <= 1'b0;
            count_reg <= '0;
        end
        else if (in_fire)
        begin
            pend_reg  <= pend_next;
            paddr_reg <= paddr_next;
            pdata_reg <= pdata_next;
            pmask_reg <= pmask_next;
            pwr_reg   <= pwr_next;
            count_reg <= count_next;
        end
    end

    lbmm_ram #(
        .WORDS (lbmm_pkg::STORE_WORDS),
        .AW    (lbmm_pkg::STORE_AW),
        .LANES (lbmm_pkg::WORD_LANES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (in_fire & serve & pwr_next),
        .rd_en   (in_fire & serve & ~pwr_next),
        .addr    (word_idx[lbmm_pkg::STORE_AW-1:0]),
        .lane_en (pmask_next),
        .wdata   (pdata_next),
        .rdata   (ram_rdata)
    );

    // Read data stays in the RAM output register until the next transaction;
    // fold it into last_read_reg only when moving on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ready_reg     <= 1'b0;
            out_rd_reg    <= 1'b0;
            last_read_reg <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
                ready_reg     <= serve;
                out_rd_reg    <= serve & ~pwr_next;
                if (out_rd_reg)
                begin
                    last_read_reg <= ram_rdata;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_data.ready_res = ready_reg;
    assign out_data.read_data = out_rd_reg ? ram_rdata : last_read_reg;

endmodule

>>> rtl/lbmm_checker.sv
// ----------------------------------------------------------------------------
// lbmm_checker
// Port-level checks of the word memory, bound to the top level.
// ----------------------------------------------------------------------------
module lbmm_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                out_valid,
    input  logic                out_stall,
    input  lbmm_pkg::out_item_t out_data
);

    // Every accepted transaction shows its result on the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted transaction produced no result");

    // A waiting result blocks the input side.
    a_stall_backs_up: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while result is stalled");

    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("result changed while stalled");

endmodule

bind latency_byte_masked_memory lbmm_checker u_lbmm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

>>> dv/latency_byte_masked_memory_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// latency_byte_masked_memory_tb
// Self-checking bench for the fixed-latency byte-masked word memory. Directed
// cases cover byte lanes, window limits and the wait counter. Randomized
// request traffic then runs over several window and wait settings. Every reply
// is checked against a transaction-level prediction of the memory.
// ----------------------------------------------------------------------------
module latency_byte_masked_memory_tb;

    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [63:0] TOP_BASE    = 64'hFFFF_FFFF_FFFF_FFF8;

    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           in_valid   = 1'b0;
    logic                           in_stall;
    lbmm_pkg::in_item_t             in_data    = '0;
    logic                           out_valid;
    logic                           out_stall  = 1'b0;
    lbmm_pkg::out_item_t            out_data;
    logic                           cfg_valid  = 1'b0;
    logic                           cfg_ready;
    logic [lbmm_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
    logic [63:0]                    cfg_data   = '0;

    latency_byte_masked_memory uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted memory state and settings
    logic [63:0]                     win_base   = '0;
    logic [lbmm_pkg::WINDOW_W-1:0]   win_bytes  = lbmm_pkg::WINDOW_RESET;
    logic [lbmm_pkg::WAIT_W-1:0]     wait_limit = '0;
    logic                            hold_valid = 1'b0;
    logic [lbmm_pkg::ADDR_W-1:0]     hold_addr  = '0;
    logic [lbmm_pkg::WORD_W-1:0]     hold_data  = '0;
    logic [lbmm_pkg::WORD_LANES-1:0] hold_mask  = '0;
    logic                            hold_write = 1'b0;
    logic [lbmm_pkg::WAIT_W-1:0]     hold_count = '0;
    logic [lbmm_pkg::WORD_W-1:0]     last_word  = '0;
    logic [lbmm_pkg::WORD_W-1:0]     mem_words    [lbmm_pkg::STORE_WORDS];
    logic [lbmm_pkg::WORD_LANES-1:0] lane_written [lbmm_pkg::STORE_WORDS];

    lbmm_pkg::out_item_t reply_q[$];
    lbmm_pkg::out_item_t want_reply;
    bit                  must_replace       = 1'b0;
    int unsigned         sender_gap_pct     = 0;
    int unsigned         receiver_stall_pct = 0;
    int                  fail_count         = 0;
    int                  cycle_count        = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < receiver_stall_pct);

    function automatic bit maps_to_store(logic [63:0] addr, output int unsigned idx);
        logic [63:0] offset;
        offset = addr - win_base;
        idx = offset[31:0] >> 3;
        return (addr >= win_base) && (offset < {48'd0, win_bytes}) &&
               ((offset >> 3) < lbmm_pkg::STORE_WORDS);
    endfunction

    function automatic bit reads_unwritten(logic [63:0] addr);
        int unsigned idx;
        if (!maps_to_store(addr, idx))
            return 1'b0;
        return lane_written[idx] != 8'hFF;
    endfunction

    // Advance the predicted state by one input transaction
    function automatic lbmm_pkg::out_item_t compute_reply(lbmm_pkg::in_item_t req);
        lbmm_pkg::out_item_t reply;
        int unsigned         idx;
        logic [63:0]         lane_bits;
        reply.ready_res = 1'b0;
        if (req.request_valid)
        begin
            hold_valid = 1'b1;
            hold_addr  = req.address;
            hold_data  = req.write_data;
            hold_mask  = req.byte_mask;
            hold_write = req.write_enable;
            hold_count = '0;
        end
        if (hold_valid)
        begin
            if (hold_count == wait_limit)
            begin
                if (maps_to_store(hold_addr, idx))
                begin
                    if (hold_write)
                    begin
                        for (int k = 0; k < lbmm_pkg::WORD_LANES; k++)
                            lane_bits[8*k +: 8] = {8{hold_mask[k]}};
                        mem_words[idx] = (mem_words[idx] & ~lane_bits) |
                                         (hold_data & lane_bits);
                        lane_written[idx] = lane_written[idx] | hold_mask;
                    end
                    else
                    begin
                        last_word = mem_words[idx];
                    end
                    hold_valid      = 1'b0;
                    hold_count      = '0;
                    reply.ready_res = 1'b1;
                end
            end
            else
            begin
                hold_count = hold_count + 1'b1;
            end
        end
        reply.read_data = last_word;
        return reply;
    endfunction

    function automatic lbmm_pkg::in_item_t random_item();
        lbmm_pkg::in_item_t item;
        item.request_valid = 1'b0;
        item.address       = {$urandom, $urandom};
        item.write_data    = {$urandom, $urandom};
        item.byte_mask     = 8'($urandom_range(255));
        item.write_enable  = 1'($urandom_range(1));
        return item;
    endfunction

    function automatic lbmm_pkg::in_item_t request(logic [63:0] addr, logic [63:0] data,
                                                   logic [7:0] mask, logic we);
        lbmm_pkg::in_item_t item;
        item.request_valid = 1'b1;
        item.address       = addr;
        item.write_data    = data;
        item.byte_mask     = mask;
        item.write_enable  = we;
        return item;
    endfunction

    task automatic send_request(lbmm_pkg::in_item_t item);
        int unsigned gap;
        gap = 0;
        if ($urandom_range(99) < sender_gap_pct)
            gap = $urandom_range(1, 3);
        if (must_replace)
            item.request_valid = 1'b1;
        if (item.request_valid)
        begin
            must_replace = 1'b0;
            // never serve a read of a word whose lanes were not all written
            if (!item.write_enable && reads_unwritten(item.address))
                item.write_enable = 1'b1;
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        reply_q.push_back(compute_reply(item));
    endtask

    task automatic send_idle(int unsigned n);
        repeat (n) send_request(random_item());
    endtask

    task automatic write_register(lbmm_pkg::cfg_reg_e idx, logic [63:0] value);
        in_valid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            lbmm_pkg::CFG_BASE_ADDRESS: win_base   = value;
            lbmm_pkg::CFG_WINDOW_BYTES: win_bytes  = value[lbmm_pkg::WINDOW_W-1:0];
            lbmm_pkg::CFG_WAIT_CYCLES:  wait_limit = value[lbmm_pkg::WAIT_W-1:0];
            default: ;
        endcase
        // a parked read that now lands on unwritten data must be replaced first
        if (hold_valid && !hold_write && reads_unwritten(hold_addr))
            must_replace = 1'b1;
    endtask

    task automatic flag_mismatch(string field, logic [63:0] want, logic [63:0] got);
        fail_count++;
        $display("%0t %s mismatch: expected %h, actual %h", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (reply_q.size() == 0)
            begin
                fail_count++;
                $display("%0t reply with none expected: expected none, actual %h",
                         $time, out_data);
            end
            else
            begin
                want_reply = reply_q.pop_front();
                if (out_data.ready_res !== want_reply.ready_res)
                    flag_mismatch("ready_res", want_reply.ready_res, out_data.ready_res);
                if (out_data.read_data !== want_reply.read_data)
                    flag_mismatch("read_data", want_reply.read_data, out_data.read_data);
            end
        end
    end

    task automatic test_mask_lanes();
        send_request(request(64'd0, '1, 8'hFF, 1'b1));
        send_request(request(64'd32760, 64'h0123_4567_89AB_CDEF, 8'hFF, 1'b1));
        send_request(request(64'd32767, '0, 8'h00, 1'b0));
        send_request(request(64'd0, '0, 8'h81, 1'b1));
        send_request(request(64'd3, '0, 8'h00, 1'b0));
        // empty mask leaves the word alone
        send_request(request(64'd0, 64'hA5A5_A5A5_A5A5_A5A5, 8'h00, 1'b1));
        send_request(request(64'd0, {$urandom, $urandom}, 8'h7E, 1'b1));
        send_request(request(64'd0, '0, 8'h00, 1'b0));
        // top of the address space is outside the window: parks forever
        send_request(request('1, '1, 8'hFF, 1'b0));
        send_idle(2);
        send_request(request(64'd32760, '0, 8'hFF, 1'b0));
        send_idle(1);
    endtask

    task automatic test_window_limits();
        write_register(lbmm_pkg::CFG_BASE_ADDRESS, TOP_BASE);
        write_register(lbmm_pkg::CFG_WINDOW_BYTES, 64'd8);
        send_request(request(TOP_BASE, {$urandom, $urandom}, 8'hFF, 1'b1));
        send_request(request('1, '0, 8'h00, 1'b0));
        send_request(request(TOP_BASE - 64'd1, '0, 8'h00, 1'b0));
        send_idle(1);
        write_register(lbmm_pkg::CFG_WINDOW_BYTES, 64'd0);
        send_request(request(TOP_BASE, '1, 8'hFF, 1'b1));
        send_idle(1);
        write_register(lbmm_pkg::CFG_BASE_ADDRESS, 64'd0);
        // odd window size: offsets 8 to 12 still map to word 1
        write_register(lbmm_pkg::CFG_WINDOW_BYTES, 64'd13);
        send_request(request(64'd12, {$urandom, $urandom}, 8'hFF, 1'b1));
        send_request(request(64'd13, '1, 8'hFF, 1'b1));
        send_request(request(64'd8, '0, 8'h00, 1'b0));
        // window larger than the store: words past the end never complete
        write_register(lbmm_pkg::CFG_WINDOW_BYTES, 64'hFFFF);
        send_request(request(64'd32768, '1, 8'hFF, 1'b1));
        send_idle(1);
        send_request(request(64'd32760, '0, 8'h00, 1'b0));
        write_register(lbmm_pkg::CFG_WINDOW_BYTES, 64'd32768);
    endtask

    task automatic test_wait_count();
        write_register(lbmm_pkg::CFG_WAIT_CYCLES, 64'd255);
        send_request(request(64'd40, {$urandom, $urandom}, 8'hFF, 1'b1));
        send_idle(256);
        write_register(lbmm_pkg::CFG_WAIT_CYCLES, 64'd200);
        send_request(request(64'd48, {$urandom, $urandom}, 8'hFF, 1'b1));
        send_idle(10);
        // count is already past the new limit: it has to wrap to get there
        write_register(lbmm_pkg::CFG_WAIT_CYCLES, 64'd3);
        send_idle(250);
        write_register(lbmm_pkg::CFG_WAIT_CYCLES, 64'd2);
        send_request(request(64'd56, '1, 8'hFF, 1'b1));
        send_idle(1);
        send_request(request(64'd40, '0, 8'h00, 1'b0));
        send_idle(3);
        send_request(request(64'd48, '0, 8'h00, 1'b0));
        send_idle(2);
        write_register(lbmm_pkg::CFG_WAIT_CYCLES, 64'd0);
    endtask

    task automatic test_random_traffic();
        lbmm_pkg::in_item_t item;
        int unsigned        pick;
        int unsigned        span;
        int unsigned        hot;
        int unsigned        word;
        logic [63:0]        word_off;
        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase == 4)
            begin
                sender_gap_pct     = 54;
                receiver_stall_pct = 35;
            end
            else if (phase == 8)
            begin
                sender_gap_pct     = 0;
                receiver_stall_pct = 0;
            end
            case (phase % 4)
                0:
                begin
                    write_register(lbmm_pkg::CFG_BASE_ADDRESS, 64'd0);
                    write_register(lbmm_pkg::CFG_WINDOW_BYTES, 64'd32768);
                    write_register(lbmm_pkg::CFG_WAIT_CYCLES, 64'd0);
                end
                1:
                begin
                    write_register(lbmm_pkg::CFG_BASE_ADDRESS, TOP_BASE);
                    write_register(lbmm_pkg::CFG_WINDOW_BYTES, 64'd8);
                    write_register(lbmm_pkg::CFG_WAIT_CYCLES, 64'd1);
                end
                2:
                begin
                    write_register(lbmm_pkg::CFG_BASE_ADDRESS,
                                   {$urandom, $urandom} & ~64'd7);
                    write_register(lbmm_pkg::CFG_WINDOW_BYTES,
                                   64'({$urandom_range(1, 4096), 3'b000}));
                    write_register(lbmm_pkg::CFG_WAIT_CYCLES, 64'($urandom_range(0, 6)));
                end
                default:
                begin
                    write_register(lbmm_pkg::CFG_BASE_ADDRESS,
                                   64'({$urandom_range(0, 1 << 20), 3'b000}));
                    write_register(lbmm_pkg::CFG_WINDOW_BYTES,
                                   64'({$urandom_range(1, 4096), 3'b000}));
                    write_register(lbmm_pkg::CFG_WAIT_CYCLES, 64'($urandom_range(2, 24)));
                end
            endcase
            span = 32'(win_bytes >> 3);
            hot  = (span > 16) ? 16 : span;
            for (int r = 0; r < 10; r++)
            begin
                item = random_item();
                item.request_valid = 1'b1;
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    // keep most traffic on a few words so reads find written data
                    word = ($urandom_range(9) == 0) ? $urandom_range(0, span - 1)
                                                    : $urandom_range(0, hot - 1);
                    word_off = 64'(word);
                    word_off = word_off * 8 + $urandom_range(0, 7);
                    item.address = win_base + word_off;
                end
                else if (pick < 80)
                begin
                    item.address = win_base - $urandom_range(1, 8);
                end
                else if (pick < 88)
                begin
                    item.address = win_base + win_bytes + $urandom_range(0, 7);
                end
                item.write_enable = ($urandom_range(99) < 55);
                if ($urandom_range(3) == 0)
                    item.byte_mask = 8'hFF;
                send_request(item);
                // mostly let the request complete, sometimes cut it short
                if ($urandom_range(4) != 0)
                    send_idle(wait_limit + $urandom_range(0, 1));
                else
                    send_idle($urandom_range(0, wait_limit));
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < lbmm_pkg::STORE_WORDS; i++)
        begin
            mem_words[i]    = '0;
            lane_written[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        sender_gap_pct     = 35;
        receiver_stall_pct = 54;
        test_mask_lanes();
        test_window_limits();
        test_wait_count();
        test_random_traffic();
        in_valid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
